>>> rtl/core/cgfr_pkg.sv
// ============================================================================
// cgfr_pkg
// Shared types, constants and helpers for the CAN GNSS frame reassembler.
// ============================================================================
package cgfr_pkg;

    // Number of sequence slots and the index width that follows from it
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Beat widths on the stream ports
    localparam int ID_W      = 11;
    localparam int PAYLOAD_W = 64;
    localparam int S_DATA_W  = 64;   // payload only, already whole bytes
    localparam int M_DATA_W  = 192;  // 187 bits of fields, zero-padded to bytes

    // Frame payload from byte 2 up: whole part in [15:0], fraction in [47:16].
    // A motion frame uses [15:0] as heading and [31:16] as speed.
    localparam int DATA_W = 48;
    localparam int MOT_W  = 32;

    // CAN identifiers
    localparam logic [ID_W-1:0] ID_ALTITUDE  = 11'h001;
    localparam logic [ID_W-1:0] ID_LONGITUDE = 11'h002;
    localparam logic [ID_W-1:0] ID_LATITUDE  = 11'h003;
    localparam logic [ID_W-1:0] ID_MOTION    = 11'h004;

    // Frame kind; the encoding is also the bit of the received flags
    typedef enum logic [1:0] {
        KIND_LAT = 2'd0,
        KIND_LON = 2'd1,
        KIND_ALT = 2'd2,
        KIND_MOT = 2'd3
    } kind_t;

    localparam logic [3:0] ALL_FLAGS = 4'hf;

    // One decoded frame
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [7:0]          mode;
        logic [DATA_W-1:0]   data;
    } frame_t;

    // One completed record
    typedef struct packed {
        logic [2:0]          slot_index;
        logic [7:0]          fix_mode;
        logic signed [15:0]  ground_speed;
        logic signed [15:0]  heading;
        logic [31:0]         altitude_fraction;
        logic signed [15:0]  altitude_whole;
        logic [31:0]         longitude_fraction;
        logic signed [15:0]  longitude_whole;
        logic [31:0]         latitude_fraction;
        logic signed [15:0]  latitude_whole;
    } record_t;

    // Fold the 3-bit slot field into the slot range by repeated subtraction
    function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] raw);
        logic [4:0] v;
        v = {2'b00, raw};
        for (int i = 0; i < 4; i++) begin
            if (v >= 5'(SLOT_COUNT)) begin
                v = v - 5'(SLOT_COUNT);
            end
        end
        return SLOT_W'(v);
    endfunction

endpackage

>>> rtl/core/cgfr_frame_decode.sv
// ============================================================================
// cgfr_frame_decode
// Input register: takes one CAN frame beat, drops unknown identifiers and
// holds the decoded frame for the slot table.
// ============================================================================
module cgfr_frame_decode (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: payload [63:0]
    input  logic [cgfr_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: can_id [10:0]
    input  logic [cgfr_pkg::ID_W-1:0]    s_tuser,
    output logic                         frm_valid,
    input  logic                         frm_ready,
    output cgfr_pkg::frame_t             frm
);
    import cgfr_pkg::*;

    logic [ID_W-1:0]      can_id;
    logic [PAYLOAD_W-1:0] payload;
    logic                 known;
    kind_t                kind;
    logic                 frm_valid_reg;
    logic                 frm_valid_next;
    frame_t               frm_reg;
    frame_t               frm_next;
    logic                 accept;

    assign can_id  = s_tuser;
    assign payload = s_tdata;

    // Map the identifier to a frame kind
    always_comb begin
        known = 1'b1;
        kind  = KIND_LAT;
        case (can_id)
            ID_LATITUDE:  kind = KIND_LAT;
            ID_LONGITUDE: kind = KIND_LON;
            ID_ALTITUDE:  kind = KIND_ALT;
            ID_MOTION:    kind = KIND_MOT;
            default:      known = 1'b0;
        endcase
    end

    // Take a new beat whenever the held frame is empty or leaves this cycle
    assign s_tready = !frm_valid_reg || frm_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        frm_next.kind = kind;
        frm_next.slot = slot_of(payload[10:8]);
        frm_next.mode = payload[7:0];
        frm_next.data = payload[PAYLOAD_W-1:16];
    end

    // Hold the frame; unknown identifiers leave no entry behind
    always_comb begin
        frm_valid_next = frm_valid_reg;
        if (accept) begin
            frm_valid_next = known;
        end else if (frm_ready) begin
            frm_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frm_valid_reg <= 1'b0;
        end else begin
            frm_valid_reg <= frm_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            frm_reg <= frm_next;
        end
    end

    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

endmodule

>>> rtl/core/cgfr_slot_table.sv
// ============================================================================
// cgfr_slot_table
// Per-slot stores and received flags. Merges the held frame with its slot and
// raises a record when all four kinds have arrived.
// ============================================================================
module cgfr_slot_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frm_valid,
    output logic               frm_ready,
    input  cgfr_pkg::frame_t   frm,
    input  logic               out_free,
    output logic               rec_valid,
    output cgfr_pkg::record_t  rec
);
    import cgfr_pkg::*;

    logic [3:0]        flags_reg      [SLOT_COUNT];
    logic [DATA_W-1:0] lat_store_reg  [SLOT_COUNT];
    logic [DATA_W-1:0] lon_store_reg  [SLOT_COUNT];
    logic [DATA_W-1:0] alt_store_reg  [SLOT_COUNT];
    logic [MOT_W-1:0]  mot_store_reg  [SLOT_COUNT];

    logic [3:0]        kind_bit;
    logic [3:0]        flags_next;
    logic              complete;
    logic              consume;
    logic [DATA_W-1:0] lat_val;
    logic [DATA_W-1:0] lon_val;
    logic [DATA_W-1:0] alt_val;
    logic [MOT_W-1:0]  mot_val;

    // Merge the new flag into the slot's flags
    assign kind_bit   = 4'b0001 << frm.kind;
    assign flags_next = flags_reg[frm.slot] | kind_bit;
    assign complete   = (flags_next & ALL_FLAGS) == ALL_FLAGS;

    // A frame that completes a record waits for room in the result register
    assign consume   = frm_valid && (!complete || out_free);
    assign frm_ready = !frm_valid || consume;
    assign rec_valid = frm_valid && complete && out_free;

    // Bypass the incoming value into the record
    assign lat_val = (frm.kind == KIND_LAT) ? frm.data : lat_store_reg[frm.slot];
    assign lon_val = (frm.kind == KIND_LON) ? frm.data : lon_store_reg[frm.slot];
    assign alt_val = (frm.kind == KIND_ALT) ? frm.data : alt_store_reg[frm.slot];
    assign mot_val = (frm.kind == KIND_MOT) ? frm.data[MOT_W-1:0]
                                            : mot_store_reg[frm.slot];

    always_comb begin
        rec.latitude_whole     = lat_val[15:0];
        rec.latitude_fraction  = lat_val[47:16];
        rec.longitude_whole    = lon_val[15:0];
        rec.longitude_fraction = lon_val[47:16];
        rec.altitude_whole     = alt_val[15:0];
        rec.altitude_fraction  = alt_val[47:16];
        rec.heading            = mot_val[15:0];
        rec.ground_speed       = mot_val[31:16];
        rec.fix_mode           = frm.mode;
        rec.slot_index         = 3'(frm.slot);
    end

    // Update flags: clear on completion, else accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                flags_reg[i] <= 4'h0;
            end
        end else if (consume) begin
            flags_reg[frm.slot] <= complete ? 4'h0 : flags_next;
        end
    end

    // Write the frame's value into its store
    always_ff @(posedge aclk) begin
        if (consume) begin
            case (frm.kind)
                KIND_LAT: lat_store_reg[frm.slot] <= frm.data;
                KIND_LON: lon_store_reg[frm.slot] <= frm.data;
                KIND_ALT: alt_store_reg[frm.slot] <= frm.data;
                KIND_MOT: mot_store_reg[frm.slot] <= frm.data[MOT_W-1:0];
                default:  ;
            endcase
        end
    end

    // A record leaves only with a held frame and a free result register
    a_rec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid |-> (frm_valid && out_free && consume))
        else $error("record raised without a free result register");

    // A completed slot starts over empty
    a_clear_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid |=> (flags_reg[$past(frm.slot)] == 4'h0))
        else $error("slot flags not cleared after record");

    // A frame that does not complete leaves its flag set
    a_flag_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && !complete) |=> flags_reg[$past(frm.slot)][$past(frm.kind)])
        else $error("received flag not set after frame");

endmodule

>>> rtl/core/cgfr_result_reg.sv
// ============================================================================
// cgfr_result_reg
// Result register: holds one completed record and packs it onto the master
// stream until the beat is taken.
// ============================================================================
module cgfr_result_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rec_valid,
    input  cgfr_pkg::record_t             rec,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: latitude_whole [15:0], latitude_fraction [47:16],
    //          longitude_whole [63:48], longitude_fraction [95:64],
    //          altitude_whole [111:96], altitude_fraction [143:112],
    //          heading [159:144], ground_speed [175:160], fix_mode [183:176],
    //          slot_index [186:184], zero pad [191:187]
    output logic [cgfr_pkg::M_DATA_W-1:0] m_tdata
);
    import cgfr_pkg::*;

    logic    m_valid_reg;
    logic    m_valid_next;
    record_t rec_reg;

    assign out_free = !m_valid_reg || m_tready;

    // Load a new record or drop the taken beat
    always_comb begin
        m_valid_next = m_valid_reg;
        if (rec_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_valid) begin
            rec_reg <= rec;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - $bits(record_t))'(0), rec_reg};

endmodule

>>> rtl/core/can_gnss_frame_reassembler_top.sv
// ============================================================================
// can_gnss_frame_reassembler_top
// Reassembles GNSS records split over four CAN frames per sequence slot.
// ============================================================================
// Takes one CAN frame beat per clock cycle unless the input is held off (see
// below), and the record completed by a beat leaves through the input register
// and then through the result register. Identifiers 1 to 4 carry altitude,
// longitude, latitude and heading/speed; byte 0 of the payload is the mode and
// byte 1 bits 2:0 the slot. Each of the eight slots keeps its last value of
// every kind in flip-flops; once all four kinds have arrived the slot's record
// goes out and its flags clear. Frames with other identifiers are taken and
// dropped. The rate is set by the single slot-table update between the two
// registers; only a stalled result register with a completing frame waiting
// holds off the input. There is no clearing pass after reset: the received
// flags reset at once, and the value stores need none.
module can_gnss_frame_reassembler_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: payload [63:0]
    input  logic [cgfr_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: can_id [10:0]
    input  logic [cgfr_pkg::ID_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: latitude_whole [15:0], latitude_fraction [47:16],
    //          longitude_whole [63:48], longitude_fraction [95:64],
    //          altitude_whole [111:96], altitude_fraction [143:112],
    //          heading [159:144], ground_speed [175:160], fix_mode [183:176],
    //          slot_index [186:184], zero pad [191:187]
    output logic [cgfr_pkg::M_DATA_W-1:0] m_tdata
);
    import cgfr_pkg::*;

    logic    frm_valid;
    logic    frm_ready;
    frame_t  frm;
    logic    out_free;
    logic    rec_valid;
    record_t rec;

    // Decode and hold the incoming frame
    cgfr_frame_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    // Update the slot and detect a completed record
    cgfr_slot_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm),
        .out_free  (out_free),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Hold the record for the master side
    cgfr_result_reg u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (rec),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
